### rtl/bas_pkg.sv
// ----------------------------------------------------------------------------
// bas_pkg: shared types and constants of the arena allocator
// Request and result item layouts, request kinds, allocator state.
// ----------------------------------------------------------------------------
`default_nettype none

package bas_pkg;

  localparam int unsigned OffW  = 17;
  localparam int unsigned BlkW  = 16;
  localparam int unsigned KindW = 2;

  // Size of the backing buffer; the effective capacity never exceeds it.
  localparam logic [OffW-1:0] ARENA_BYTES  = 17'd65536;
  localparam logic [OffW-1:0] CAP_RESET    = 17'd65536;
  localparam logic [OffW-1:0] LEN_SAT      = 17'h1FFFF;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef enum logic [KindW-1:0] {
    KIND_ALLOC  = 2'd0,
    KIND_FREE   = 2'd1,
    KIND_RESIZE = 2'd2
  } kind_e;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [BlkW-1:0]  block_offset;
    logic [OffW-1:0]  request_size;
    logic [OffW-1:0]  new_length;
  } req_t;

  typedef struct packed {
    logic            status;
    logic [OffW-1:0] result_offset;
    logic            moved;
  } rsp_t;

  typedef struct packed {
    logic [OffW-1:0] used_top;
    logic            hole_valid;
    logic [OffW-1:0] hole_start;
    logic [OffW-1:0] hole_length;
  } arena_state_t;

endpackage

`default_nettype wire

### rtl/bas_step.sv
// ----------------------------------------------------------------------------
// bas_step: one allocator request against the current state
// Combinational next state and result for allocate, free and resize.
// ----------------------------------------------------------------------------
`default_nettype none

module bas_step (
  input  bas_pkg::arena_state_t cur_i,
  input  bas_pkg::req_t         req_i,
  input  logic [16:0]           capacity_i,
  output bas_pkg::arena_state_t nxt_o,
  output bas_pkg::rsp_t         rsp_o
);
  import bas_pkg::*;

  logic [OffW-1:0] eff_cap;
  logic [OffW-1:0] space;
  logic [OffW-1:0] blk;
  logic [OffW-1:0] size;
  logic [OffW-1:0] nlen;
  logic [OffW:0]   blk_end;
  logic [OffW:0]   hole_end;
  logic [OffW:0]   merge_sum;
  logic [OffW-1:0] merge_len;
  logic            below_top;
  logic            is_last;
  logic            left;
  logic            right;
  logic            create;
  logic            hole_fit;
  logic            grow_fits;
  logic [OffW:0]   resize_top;
  arena_state_t    freed;
  logic            free_ok;
  logic            fail;
  logic            moved;
  logic [OffW-1:0] res;

  always_comb begin
    eff_cap   = (capacity_i < ARENA_BYTES) ? capacity_i : ARENA_BYTES;
    // Top above capacity after a lowered capacity: no free space.
    space     = (cur_i.used_top > eff_cap) ? '0 : (eff_cap - cur_i.used_top);
    blk       = {1'b0, req_i.block_offset};
    size      = req_i.request_size;
    nlen      = req_i.new_length;
    blk_end   = {1'b0, blk} + {1'b0, size};   // up to 65535 + 131071, keep the carry
    below_top = blk < cur_i.used_top;
    is_last   = blk_end == {1'b0, cur_i.used_top};
    hole_end  = {1'b0, cur_i.hole_start} + {1'b0, cur_i.hole_length};
    merge_sum = {1'b0, cur_i.hole_length} + {1'b0, size};
    merge_len = merge_sum[OffW] ? LEN_SAT : merge_sum[OffW-1:0];
    left      = cur_i.hole_valid && (blk_end == {1'b0, cur_i.hole_start});
    right     = cur_i.hole_valid && (hole_end == {1'b0, blk});
    create    = !cur_i.hole_valid || (size > cur_i.hole_length);
    hole_fit  = cur_i.hole_valid && (cur_i.hole_length >= size);
    grow_fits = (nlen <= size) || ((nlen - size) <= space);
    resize_top = {1'b0, blk} + {1'b0, nlen};

    // Hole update of a free of an inner block (not ending at the top).
    freed   = cur_i;
    free_ok = 1'b1;
    if (left) begin
      freed.hole_start  = blk;
      freed.hole_length = merge_len;
    end else if (right) begin
      freed.hole_length = merge_len;
    end else if (create) begin
      freed.hole_valid  = 1'b1;
      freed.hole_start  = blk;
      freed.hole_length = size;
    end else begin
      free_ok = 1'b0;
    end

    nxt_o = cur_i;
    fail  = STATUS_FAIL;
    moved = 1'b0;
    res   = '0;

    case (req_i.kind)
      KIND_ALLOC: begin
        if (size <= eff_cap) begin
          if (hole_fit) begin
            res               = cur_i.hole_start;
            nxt_o.hole_start  = cur_i.hole_start + size;
            nxt_o.hole_length = cur_i.hole_length - size;
            if (cur_i.hole_length == size) begin
              nxt_o.hole_valid = 1'b0;
            end
            fail = STATUS_OK;
          end else if (size <= space) begin
            res            = cur_i.used_top;
            nxt_o.used_top = cur_i.used_top + size;
            fail           = STATUS_OK;
          end
        end
      end
      KIND_FREE: begin
        if (below_top) begin
          if (is_last) begin
            nxt_o.used_top = blk;
            fail           = STATUS_OK;
          end else begin
            nxt_o = freed;
            fail  = free_ok ? STATUS_OK : STATUS_FAIL;
          end
        end
      end
      KIND_RESIZE: begin
        if (below_top) begin
          if (is_last) begin
            if (grow_fits) begin
              nxt_o.used_top = resize_top[OffW-1:0];
              res            = blk;
              fail           = STATUS_OK;
            end
          end else begin
            // The block is released even when the new size does not fit.
            nxt_o = freed;
            if (space >= nlen) begin
              res            = cur_i.used_top;
              nxt_o.used_top = cur_i.used_top + nlen;
              moved          = 1'b1;
              fail           = STATUS_OK;
            end
          end
        end
      end
      default: begin
        fail = STATUS_FAIL;
      end
    endcase

    rsp_o.status        = fail;
    rsp_o.result_offset = (fail == STATUS_FAIL) ? '0 : res;
    rsp_o.moved         = (fail == STATUS_FAIL) ? 1'b0 : moved;
  end

endmodule

`default_nettype wire

### rtl/bump_allocator_single_hole_core.sv
// ----------------------------------------------------------------------------
// bump_allocator_single_hole_core: arena allocator with a top and one hole
// Serves allocate, free and resize requests over offsets into a fixed
// buffer, keeping a used-top pointer and a single free hole.
// ----------------------------------------------------------------------------
//
//  Channel | Signals                            | Direction | Item
//  --------+------------------------------------+-----------+---------------
//  in      | in_valid_i, in_ready_o, in_data_i  | sink      | req_t request
//  out     | out_valid_o, out_ready_i, out_data_o | source  | rsp_t result
//  cfg     | cfg_we_i, cfg_wdata_i              | sink      | capacity write
//
//  One item per cycle sustained while the output takes results; an item's
//  result is valid on the output after the input and result registers.
//  The rate is set by the single next-state pass on the allocator state
//  registers, done as the item moves from the input register to the
//  result register.
//  Reset: both stages empty, used top 0, no hole, capacity 65536.
//  A stalled output holds its item; the input register takes items while
//  empty or while its item can advance to the next stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bump_allocator_single_hole_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bas_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bas_pkg::rsp_t out_data_o,
  input  logic          cfg_we_i,
  input  logic [16:0]   cfg_wdata_i
);
  import bas_pkg::*;

  // Capacity register.
  logic [OffW-1:0] capacity_q;

  // Input stage.
  logic            in_vld_q;
  req_t            in_q;

  // Allocator state.
  arena_state_t    state_q;
  arena_state_t    state_d;

  // Result stage.
  logic            out_vld_q;
  rsp_t            out_q;
  rsp_t            rsp_d;

  logic            adv;   // input item moves to the result register

  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;

  bas_step u_step (
    .cur_i      (state_q),
    .req_i      (in_q),
    .capacity_i (capacity_q),
    .nxt_o      (state_d),
    .rsp_o      (rsp_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      capacity_q <= cfg_wdata_i;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  // State commits exactly when the item's result is captured.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (adv) begin
      state_q <= state_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= rsp_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // The top never runs past the backing buffer.
  a_top_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.used_top <= ARENA_BYTES)
    else $error("used top beyond arena");

  // State moves only with an item passing to the result stage.
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(state_q))
    else $error("state changed without an item");

  // A failed result carries no offset and no move flag.
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.status == STATUS_FAIL) |->
      (out_q.result_offset == '0 && !out_q.moved))
    else $error("failed result not cleared");

  // A stalled result is not overwritten.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_ready_i) |=> (out_vld_q && $stable(out_q)))
    else $error("stalled result lost");

endmodule

`default_nettype wire

### dv/bump_allocator_single_hole_core_tb.sv
// ----------------------------------------------------------------------------
// bump_allocator_single_hole_core_tb: self-checking bench for the arena core
// Sends allocate, free and resize requests over the valid/ready input, keeps
// its own copy of the top pointer, hole and capacity, and checks every result
// item in order, field by field. The capacity changes between phases.
// ----------------------------------------------------------------------------
module bump_allocator_single_hole_core_tb;
  import bas_pkg::*;

  // Request kind with no operation behind it; the core must refuse it.
  localparam logic [KindW-1:0] KIND_BAD = 2'd3;

  // Directed rows either carry a typed-in result or defer to the predictor.
  localparam bit CHK_TYPED = 1'b1;
  localparam bit CHK_MODEL = 1'b0;

  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
  localparam int SETTLE_CYCLES  = 4;     // core holds two stages
  localparam int TAIL_CYCLES    = 10;
  localparam int PHASE_ITEMS    = 118;
  localparam int N_PHASES       = 7;
  localparam int MAX_LIVE       = 48;
  localparam int REPORT_MAX     = 10;

  typedef struct {
    req_t rq;
    bit   chk;
    rsp_t want;
  } stim_row_t;

  // A block the bench believes is allocated: lets random frees and resizes
  // hit real blocks instead of only noise.
  typedef struct {
    bit [BlkW-1:0] off;
    bit [OffW-1:0] len;
  } live_blk_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  req_t        in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  rsp_t        out_data_o;
  logic        cfg_we_i    = 1'b0;
  logic [16:0] cfg_wdata_i = '0;

  // Predicted allocator state.
  bit [OffW-1:0] p_cap;
  bit [OffW-1:0] p_top;
  bit            p_hole_v;
  bit [OffW-1:0] p_hole_start;
  bit [OffW-1:0] p_hole_len;

  rsp_t      pending_q[$];  // results still owed by the core, oldest first
  stim_row_t dir_rows[$];
  live_blk_t live_q[$];

  int mismatches    = 0;
  int idle_cycles   = 0;
  int stall_left    = 0;
  bit no_idle       = 1'b0;
  int n_by_kind[4]  = '{0, 0, 0, 0};
  int n_ok          = 0;
  int n_moved       = 0;
  int n_hole_serves = 0;
  int n_cap_writes  = 0;
  rsp_t mon_want;

  bump_allocator_single_hole_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic bit [OffW-1:0] sat_len(input int unsigned v);
    return (v > LEN_SAT) ? LEN_SAT : v[OffW-1:0];
  endfunction

  // Return a block to the arena: shrink the top if it is the last block,
  // else grow the hole from either side, or take over a shorter hole.
  function automatic bit release_block(input int unsigned blk, input int unsigned size);
    int unsigned blk_end;
    bit          left;
    bit          right;
    bit          take_over;
    blk_end = blk + size;
    if (blk >= p_top) return 1'b0;
    if (blk_end == p_top) begin
      p_top = blk[OffW-1:0];
      return 1'b1;
    end
    left  = p_hole_v && (blk_end == p_hole_start);
    right = p_hole_v && ((p_hole_start + p_hole_len) == blk);
    if (left) begin
      p_hole_start = blk[OffW-1:0];
      p_hole_len   = sat_len(p_hole_len + size);
    end else if (right) begin
      p_hole_len = sat_len(p_hole_len + size);
    end
    // compared against the hole as it stands after any merge
    take_over = !p_hole_v || (size > p_hole_len);
    if (take_over) begin
      p_hole_v     = 1'b1;
      p_hole_start = blk[OffW-1:0];
      p_hole_len   = size[OffW-1:0];
    end
    return left || right || take_over;
  endfunction

  function automatic rsp_t arena_predict(input req_t r);
    int unsigned eff_cap;
    int unsigned room;
    int unsigned blk;
    int unsigned size;
    int unsigned nlen;
    int unsigned res;
    int unsigned new_top;
    bit          ok;
    bit          reloc;
    rsp_t        o;
    eff_cap = 32'((p_cap < ARENA_BYTES) ? p_cap : ARENA_BYTES);
    // top above a lowered capacity leaves no room, but is left alone
    room    = (p_top > eff_cap) ? 0 : eff_cap - p_top;
    blk     = 32'(r.block_offset);
    size    = 32'(r.request_size);
    nlen    = 32'(r.new_length);
    res     = 0;
    ok      = 1'b0;
    reloc   = 1'b0;
    case (r.kind)
      KIND_ALLOC: begin
        if (size <= eff_cap) begin
          if (p_hole_v && p_hole_len >= size) begin
            res          = 32'(p_hole_start);
            p_hole_start = p_hole_start + size[OffW-1:0];
            p_hole_len   = p_hole_len - size[OffW-1:0];
            if (p_hole_len == '0) p_hole_v = 1'b0;
            ok = 1'b1;
            n_hole_serves++;
          end else if (size <= room) begin
            res   = 32'(p_top);
            p_top = p_top + size[OffW-1:0];
            ok    = 1'b1;
          end
        end
      end
      KIND_FREE: ok = release_block(blk, size);
      KIND_RESIZE: begin
        if (blk < p_top) begin
          if (blk + size == p_top) begin
            // last block: grow or shrink in place, keep it if it will not fit
            if (nlen <= size || nlen - size <= room) begin
              new_top = blk + nlen;
              p_top   = new_top[OffW-1:0];
              res     = blk;
              ok      = 1'b1;
            end
          end else begin
            // inner block: it is given back even when the move then fails
            void'(release_block(blk, size));
            if (room >= nlen) begin
              res   = 32'(p_top);
              p_top = p_top + nlen[OffW-1:0];
              reloc = 1'b1;
              ok    = 1'b1;
            end
          end
        end
      end
      default: ok = 1'b0;
    endcase
    o.status        = ok ? STATUS_OK : STATUS_FAIL;
    o.result_offset = ok ? res[OffW-1:0] : '0;
    o.moved         = ok & reloc;
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Random helpers
  // --------------------------------------------------------------------------
  // Mostly small sizes so the arena does not fill in a handful of items.
  function automatic bit [OffW-1:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return OffW'($urandom_range(1, 64));
    if (r < 88) return OffW'($urandom_range(65, 2048));
    if (r < 94) return '0;
    return OffW'($urandom_range(0, LEN_SAT));
  endfunction

  // Idle length: mostly none, some short, a few long.
  function automatic int pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void add_row(input logic [KindW-1:0] kind, input int unsigned blk,
                                  input int unsigned size, input int unsigned nlen,
                                  input bit chk, input logic st, input int unsigned off,
                                  input bit mv);
    stim_row_t row;
    row.rq.kind               = kind;
    row.rq.block_offset       = blk[BlkW-1:0];
    row.rq.request_size       = size[OffW-1:0];
    row.rq.new_length         = nlen[OffW-1:0];
    row.chk                   = chk;
    row.want.status           = st;
    row.want.result_offset    = off[OffW-1:0];
    row.want.moved            = mv;
    dir_rows.push_back(row);
  endfunction

  // --------------------------------------------------------------------------
  // Request side. Tasks are entered and left just after a falling edge.
  // --------------------------------------------------------------------------
  task automatic send_req(input req_t rq, input bit chk, input rsp_t want,
                          output rsp_t pred);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= rq;
    @(posedge clk_i);
    while (in_ready_o !== 1'b1) @(posedge clk_i);
    // accepted on this edge: advance the predicted state in request order
    pred = arena_predict(rq);
    pending_q.push_back((chk == CHK_TYPED) ? want : pred);
    n_by_kind[rq.kind]++;
    if (pred.status == STATUS_OK) n_ok++;
    if (pred.moved) n_moved++;
    @(negedge clk_i);
  endtask

  // Hold off the sender until every owed result is back and the pipe is empty.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_capacity(input bit [OffW-1:0] value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    p_cap = value;
    n_cap_writes++;
  endtask

  // Random phase: mostly requests on blocks known to be live, so frees and
  // resizes reach the merge, take-over and move paths; the rest is noise.
  task automatic run_phase(input int items);
    req_t rq;
    rsp_t pred;
    rsp_t none;
    int   idx;
    int   sel;
    live_blk_t nb;
    none = '0;
    for (int i = 0; i < items; i++) begin
      idx = -1;
      sel = $urandom_range(0, 99);
      rq  = '0;
      rq.new_length = OffW'($urandom_range(0, LEN_SAT));
      if (sel < 40) begin
        rq.kind         = KIND_ALLOC;
        rq.request_size = pick_size();
      end else if (sel < 85 && live_q.size() != 0) begin
        idx             = $urandom_range(0, live_q.size() - 1);
        rq.kind         = (sel < 65) ? KIND_FREE : KIND_RESIZE;
        rq.block_offset = live_q[idx].off;
        rq.request_size = live_q[idx].len;
        rq.new_length   = pick_size();
      end else if (sel < 90) begin
        // zero-length allocate or free near the used region
        rq.kind         = ($urandom_range(0, 1) != 0) ? KIND_FREE : KIND_ALLOC;
        rq.block_offset = BlkW'($urandom_range(0, p_top));
        rq.request_size = '0;
      end else begin
        rq.kind         = KindW'($urandom_range(0, 3));
        rq.block_offset = ($urandom_range(0, 1) != 0) ? BlkW'($urandom)
                                                       : BlkW'($urandom_range(0, p_top));
        rq.request_size = ($urandom_range(0, 1) != 0) ? OffW'($urandom_range(0, LEN_SAT))
                                                       : pick_size();
      end
      send_req(rq, CHK_MODEL, none, pred);

      // keep the live list in step with what the core should now hold
      if (idx >= 0) begin
        if (rq.kind == KIND_FREE) begin
          if (pred.status == STATUS_OK) live_q.delete(idx);
        end else if (pred.status == STATUS_FAIL || pred.moved) begin
          live_q.delete(idx);
        end else begin
          live_q[idx].len = rq.new_length;
        end
      end
      if (pred.status == STATUS_OK && (rq.kind == KIND_ALLOC || pred.moved) &&
          pred.result_offset <= 17'hFFFF && live_q.size() < MAX_LIVE) begin
        nb.off = pred.result_offset[BlkW-1:0];
        nb.len = (rq.kind == KIND_ALLOC) ? rq.request_size : rq.new_length;
        live_q.push_back(nb);
      end

      if ($urandom_range(0, 59) == 0) drain_results();
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, set on the falling edge.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left = stall_left - 1;
    end else if (!no_idle && $urandom_range(0, 3) == 0) begin
      out_ready_i <= 1'b0;
      stall_left = pick_gap();
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic note_mismatch(input string what, input rsp_t want, input rsp_t got);
    mismatches++;
    if (mismatches <= REPORT_MAX) begin
      $display("%0t %s: want status %0d offset %0d moved %0d, got status %0d offset %0d moved %0d",
               $time, what, want.status, want.result_offset, want.moved,
               got.status, got.result_offset, got.moved);
    end
  endtask

  // Result checker and watchdog, sampled on the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_q.size() == 0) begin
          note_mismatch("result with no request pending", '0, out_data_o);
        end else begin
          mon_want = pending_q.pop_front();
          if (out_data_o.status !== mon_want.status ||
              out_data_o.result_offset !== mon_want.result_offset ||
              out_data_o.moved !== mon_want.moved) begin
            note_mismatch("wrong result", mon_want, out_data_o);
          end
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("no item moved for %0d cycles, %0d results owed", idle_cycles,
                 pending_q.size());
        $display("bump_allocator_single_hole_core: mismatch");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rsp_t          pred;
    bit [OffW-1:0] caps[N_PHASES];

    p_cap        = CAP_RESET;
    p_top        = '0;
    p_hole_v     = 1'b0;
    p_hole_start = '0;
    p_hole_len   = '0;

    // Directed walk at reset capacity. Each row leaves the arena in a state
    // the next one builds on.
    // zero-size allocate right after reset comes from the top at 0
    add_row(KIND_ALLOC,  0,       0,      0,      CHK_TYPED, STATUS_OK,   0, 0);
    // one byte over the arena
    add_row(KIND_ALLOC,  0,       65537,  0,      CHK_TYPED, STATUS_FAIL, 0, 0);
    add_row(KIND_ALLOC,  0,       100,    0,      CHK_TYPED, STATUS_OK,   0, 0);
    // free of a block sitting at the top offset
    add_row(KIND_FREE,   100,     10,     0,      CHK_TYPED, STATUS_FAIL, 0, 0);
    // unknown kind with every other field at its maximum
    add_row(KIND_BAD,    'hFFFF,  'h1FFFF, 'h1FFFF, CHK_TYPED, STATUS_FAIL, 0, 0);
    add_row(KIND_ALLOC,  0,       50,     0,      CHK_MODEL, STATUS_OK,   0, 0);
    add_row(KIND_ALLOC,  0,       30,     0,      CHK_MODEL, STATUS_OK,   0, 0);
    // inner free with no hole: becomes the hole
    add_row(KIND_FREE,   100,     50,     0,      CHK_MODEL, STATUS_OK,   0, 0);
    // allocate served from the hole
    add_row(KIND_ALLOC,  0,       20,     0,      CHK_MODEL, STATUS_OK,   0, 0);
    // last block freed: top shrinks
    add_row(KIND_FREE,   150,     30,     0,      CHK_MODEL, STATUS_OK,   0, 0);
    // larger block replaces the shorter hole
    add_row(KIND_FREE,   0,       100,    0,      CHK_MODEL, STATUS_OK,   0, 0);
    // neither touches nor beats the hole
    add_row(KIND_FREE,   120,     10,     0,      CHK_MODEL, STATUS_OK,   0, 0);
    // merge on the right edge of the hole
    add_row(KIND_FREE,   100,     20,     0,      CHK_MODEL, STATUS_OK,   0, 0);
    // last block grows, then shrinks to nothing, in place
    add_row(KIND_RESIZE, 130,     20,     1000,   CHK_MODEL, STATUS_OK,   0, 0);
    add_row(KIND_RESIZE, 130,     1000,   0,      CHK_MODEL, STATUS_OK,   0, 0);
    // inner block moves to the top
    add_row(KIND_RESIZE, 5,       10,     40,     CHK_MODEL, STATUS_OK,   0, 0);
    // resize of a block at the top offset
    add_row(KIND_RESIZE, 170,     10,     20,     CHK_TYPED, STATUS_FAIL, 0, 0);
    // last block cannot grow that far
    add_row(KIND_RESIZE, 130,     40,     'h1FFFF, CHK_MODEL, STATUS_OK,  0, 0);
    // inner block does not fit at the top but is still merged into the hole
    add_row(KIND_RESIZE, 120,     5,      65536,  CHK_MODEL, STATUS_OK,   0, 0);
    // empty the hole exactly
    add_row(KIND_ALLOC,  0,       125,    0,      CHK_MODEL, STATUS_OK,   0, 0);
    // zero-length hole, then a zero-size allocate that retires it
    add_row(KIND_FREE,   10,      0,      0,      CHK_MODEL, STATUS_OK,   0, 0);
    add_row(KIND_ALLOC,  0,       0,      0,      CHK_MODEL, STATUS_OK,   0, 0);
    // huge hole, then a left merge that saturates its length
    add_row(KIND_FREE,   50,      'h1FFFF, 0,     CHK_MODEL, STATUS_OK,   0, 0);
    add_row(KIND_FREE,   40,      10,     0,      CHK_MODEL, STATUS_OK,   0, 0);
    // full-arena allocate out of that hole; the next one wraps its start
    add_row(KIND_ALLOC,  0,       65536,  0,      CHK_MODEL, STATUS_OK,   0, 0);
    add_row(KIND_ALLOC,  0,       65535,  0,      CHK_MODEL, STATUS_OK,   0, 0);
    // resize of the block at offset 0
    add_row(KIND_RESIZE, 0,       4,      8,      CHK_MODEL, STATUS_OK,   0, 0);

    // capacity per random phase: small, none, all ones, below the top,
    // two random ones, then back to the reset value
    caps = '{17'd2048, 17'd0, LEN_SAT, 17'd300, 17'($urandom_range(1000, 8000)),
             17'($urandom_range(0, LEN_SAT)), CAP_RESET};

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      send_req(dir_rows[i].rq, dir_rows[i].chk, dir_rows[i].want, pred);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      set_capacity(caps[ph]);
      // some phases run with no idling on either side
      no_idle = (ph % 3 == 2);
      run_phase(PHASE_ITEMS);
    end
    no_idle = 1'b0;

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("ran %0d requests: %0d allocate, %0d free, %0d resize, %0d unknown kind",
             n_by_kind[0] + n_by_kind[1] + n_by_kind[2] + n_by_kind[3],
             n_by_kind[0], n_by_kind[1], n_by_kind[2], n_by_kind[3]);
    $display("%0d succeeded, %0d served from the hole, %0d relocated, %0d capacity writes",
             n_ok, n_hole_serves, n_moved, n_cap_writes);
    if (mismatches == 0) begin
      $display("bump_allocator_single_hole_core: match");
    end else begin
      $display("%0d result mismatches", mismatches);
      $display("bump_allocator_single_hole_core: mismatch");
    end
    $finish;
  end

endmodule
